### rtl/core/nfba_pkg.sv
package nfba_pkg;

    // bitmap word width, bit offset width within a word, block index width and status width
    localparam int WORD_W   = 32;
    localparam int OFFS_W   = 5;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_GRANT = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FREED = 2'd2;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE,
        ST_RESP
    } state_t;

endpackage

### rtl/core/next_fit_block_allocator.sv
// Next-fit allocator over a used-block bitmap held in a 32-bit-word memory.
// Allocate: reads the word at the search pointer and scans word by word, wrapping, until it claims a free
// block; free: clears the block's bit if set. Full pool or out-of-range free go straight to the response.
// The result is registered once the output register is free; no new item is accepted before that.
// Reset: search pointer and used count clear at once; the bitmap is then cleared
// by a pass over every word during which no item is accepted.
module next_fit_block_allocator #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [nfba_pkg::INDEX_W-1:0]  s_free_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [nfba_pkg::INDEX_W-1:0]  m_block_index,
    output logic [nfba_pkg::STATUS_W-1:0] m_status
);

    localparam int WORD_W    = nfba_pkg::WORD_W;
    localparam int OFFS_W    = nfba_pkg::OFFS_W;
    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IDX_W     = $clog2(NUM_BLOCKS);
    localparam int EXT_W     = WORD_AW + OFFS_W;
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
    localparam int LAST_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_W;

    localparam logic [WORD_AW-1:0] LAST_WORD  = WORD_AW'(NUM_WORDS - 1);
    localparam logic [IDX_W-1:0]   LAST_INDEX = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [CNT_W-1:0]   FULL_COUNT = CNT_W'(NUM_BLOCKS);
    localparam logic [WORD_W-1:0]  LAST_MASK  = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);

    // lowest set bit of a word
    function automatic logic [OFFS_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
        logic [OFFS_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = OFFS_W'(i);
            end
        end
        return r;
    endfunction

    // bitmap memory
    logic [WORD_W-1:0]  bitmap_mem [NUM_WORDS];
    logic [WORD_W-1:0]  rdata_reg;
    logic [WORD_AW-1:0] raddr;
    logic [WORD_AW-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
    logic               wen;

    // control and state registers
    nfba_pkg::state_t                state_reg, state_next;
    logic [WORD_AW-1:0]              clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]                ptr_reg, ptr_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [WORD_AW-1:0]              word_reg, word_next;
    logic [OFFS_W-1:0]               offs_reg, offs_next;
    logic                            first_reg, first_next;
    logic [nfba_pkg::INDEX_W-1:0]    res_index_reg, res_index_next;
    logic [nfba_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                            m_valid_reg, m_valid_next;
    logic [nfba_pkg::INDEX_W-1:0]    m_index_reg, m_index_next;
    logic [nfba_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;

    // helper values
    logic [EXT_W-1:0]  ptr_ext;
    logic [EXT_W-1:0]  fidx_ext;
    logic              fidx_in_range;
    logic [WORD_W-1:0] valid_mask;
    logic [WORD_W-1:0] start_mask;
    logic [WORD_W-1:0] free_bits;
    logic [OFFS_W-1:0] hit_bit;
    logic [IDX_W-1:0]  hit_index;
    logic [WORD_W-1:0] bit_sel;

    assign ptr_ext       = EXT_W'(ptr_reg);
    assign fidx_ext      = EXT_W'(s_free_index);
    assign fidx_in_range = 32'(s_free_index) < NUM_BLOCKS;

    // free candidates in the word just read
    assign valid_mask = (word_reg == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}};
    assign start_mask = first_reg ? ({WORD_W{1'b1}} << offs_reg) : {WORD_W{1'b1}};
    assign free_bits  = ~rdata_reg & valid_mask & start_mask;
    assign hit_bit    = lowest_bit(free_bits);
    assign hit_index  = IDX_W'({word_reg, hit_bit});
    assign bit_sel    = WORD_W'(1) << offs_reg;

    // memory port, read data registered
    always_ff @(posedge aclk) begin
        if (wen) begin
            bitmap_mem[waddr] <= wdata;
        end
        rdata_reg <= bitmap_mem[raddr];
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= nfba_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            ptr_reg      <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            ptr_reg      <= ptr_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        word_reg       <= word_next;
        offs_reg       <= offs_next;
        first_reg      <= first_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        m_index_reg    <= m_index_next;
        m_status_reg   <= m_status_next;
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        word_next       = word_reg;
        offs_next       = offs_reg;
        first_next      = first_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_index_next    = m_index_reg;
        m_status_next   = m_status_reg;
        raddr           = word_reg;
        waddr           = word_reg;
        wdata           = rdata_reg;
        wen             = 1'b0;
        s_ready         = 1'b0;

        // output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            nfba_pkg::ST_CLEAR: begin
                wen   = 1'b1;
                waddr = clr_addr_reg;
                wdata = '0;
                if (clr_addr_reg == LAST_WORD) begin
                    clr_addr_next = '0;
                    state_next    = nfba_pkg::ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            nfba_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_func == nfba_pkg::FUNC_ALLOC) begin
                    raddr = ptr_ext[EXT_W-1:OFFS_W];
                end else begin
                    raddr = fidx_ext[EXT_W-1:OFFS_W];
                end
                if (s_valid) begin
                    first_next = 1'b1;
                    if (s_func == nfba_pkg::FUNC_ALLOC) begin
                        word_next = ptr_ext[EXT_W-1:OFFS_W];
                        offs_next = ptr_ext[OFFS_W-1:0];
                        if (count_reg == FULL_COUNT) begin
                            res_index_next  = '0;
                            res_status_next = nfba_pkg::STAT_FULL;
                            state_next      = nfba_pkg::ST_RESP;
                        end else begin
                            state_next = nfba_pkg::ST_SCAN;
                        end
                    end else begin
                        word_next       = fidx_ext[EXT_W-1:OFFS_W];
                        offs_next       = fidx_ext[OFFS_W-1:0];
                        res_index_next  = s_free_index;
                        res_status_next = nfba_pkg::STAT_FREED;
                        if (fidx_in_range) begin
                            ptr_next   = IDX_W'(s_free_index);
                            state_next = nfba_pkg::ST_FREE;
                        end else begin
                            state_next = nfba_pkg::ST_RESP;
                        end
                    end
                end
            end

            nfba_pkg::ST_SCAN: begin
                if (free_bits != '0) begin
                    // claim the block and move the pointer one past it
                    wen             = 1'b1;
                    wdata           = rdata_reg | (WORD_W'(1) << hit_bit);
                    count_next      = count_reg + 1'b1;
                    ptr_next        = (hit_index == LAST_INDEX) ? '0 : hit_index + 1'b1;
                    res_index_next  = nfba_pkg::INDEX_W'(hit_index);
                    res_status_next = nfba_pkg::STAT_GRANT;
                    state_next      = nfba_pkg::ST_RESP;
                end else begin
                    // move on to the next word, wrapping at the end of the pool
                    word_next  = (word_reg == LAST_WORD) ? '0 : word_reg + 1'b1;
                    raddr      = word_next;
                    first_next = 1'b0;
                end
            end

            nfba_pkg::ST_FREE: begin
                if ((rdata_reg & bit_sel) != '0) begin
                    wen        = 1'b1;
                    wdata      = rdata_reg & ~bit_sel;
                    count_next = count_reg - 1'b1;
                end
                state_next = nfba_pkg::ST_RESP;
            end

            nfba_pkg::ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_index_next  = res_index_reg;
                    m_status_next = res_status_reg;
                    state_next    = nfba_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = nfba_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_block_index = m_index_reg;
    assign m_status      = m_status_reg;

endmodule
